// ----- rtl/core/lav_pkg.sv -----
// Shared widths, constants and rounding helpers for the look-at view matrix block.
// No dependencies; imported by lav_unit and look_at_view_matrix_top.
`default_nettype none
package lav_pkg;

  // Fixed widths of the external fields.
  localparam int unsigned DATA_W = 32;
  // Default number of fractional bits of every fixed-point field.
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Width of the working window a vector is normalised into before the length is taken.
  localparam int unsigned NORM_W = 31;
  // Width of the sum of squares and number of root steps taken over it.
  localparam int unsigned SUM_W = 64;
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  // Width of the exact products, sums and rounded intermediates.
  localparam int unsigned WIDE_W = 66;

  localparam logic signed [WIDE_W-1:0] MAX32 = WIDE_W'(2147483647);
  localparam logic signed [WIDE_W-1:0] MIN32 = -WIDE_W'(2147483647) - WIDE_W'(1);

  // Shift right by fb bits, rounding half away from zero.
  function automatic logic signed [WIDE_W-1:0] round_shr(input logic signed [WIDE_W-1:0] x,
                                                         input int unsigned fb);
    logic signed [WIDE_W-1:0] half;
    half = WIDE_W'(1) <<< (fb - 1);
    if (x >= 0) begin
      return (x + half) >>> fb;
    end
    return -((-x + half) >>> fb);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    if (x > MAX32) begin
      return MAX32[DATA_W-1:0];
    end
    if (x < MIN32) begin
      return MIN32[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lav_unit.sv -----
// Pipelined vector normaliser: magnitude, normalising shift, square root and division.
// Depends on lav_pkg; instantiated twice by look_at_view_matrix_top.
`default_nettype none
module lav_unit #(
  parameter int unsigned IN_W      = 64,
  parameter int unsigned FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [IN_W-1:0]      vec_i [3],
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic                        zero_o,
  output logic signed [FRAC_BITS+1:0] res_o [3],
  output logic [SIDE_W-1:0]           side_o
);
  import lav_pkg::*;

  localparam int unsigned SH_STEPS = $clog2(IN_W);
  localparam int unsigned CW       = SIDE_W + 3;
  localparam int unsigned ND       = NORM_W + FRAC_BITS + 1;
  localparam int unsigned DW       = ND + 1;
  localparam int unsigned QW       = FRAC_BITS + 1;
  localparam int unsigned RW       = FRAC_BITS + 2;
  localparam int unsigned ROOT_W   = SQRT_STEPS;

  // Magnitudes and signs.
  logic [IN_W-1:0] mag0_q [3];
  logic [CW-1:0]   ctl0_q;
  logic            v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag0_q[i] <= vec_i[i][IN_W-1] ? IN_W'(-vec_i[i]) : IN_W'(vec_i[i]);
      end
      ctl0_q <= {side_i, vec_i[0][IN_W-1], vec_i[1][IN_W-1], vec_i[2][IN_W-1]};
    end
  end

  // Largest magnitude, then a left shift of all three in binary steps.
  logic [IN_W-1:0] nm_q [SH_STEPS+1][3];
  logic [IN_W-1:0] nx_q [SH_STEPS+1];
  logic [CW:0]     nc_q [SH_STEPS+1];
  logic            nv_q [SH_STEPS+1];
  logic [IN_W-1:0] max_d;

  always_comb begin
    max_d = (mag0_q[0] > mag0_q[1]) ? mag0_q[0] : mag0_q[1];
    max_d = (mag0_q[2] > max_d) ? mag0_q[2] : max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q[0] <= 1'b0;
    end else if (en_i) begin
      nv_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q[0] <= mag0_q;
      nx_q[0] <= max_d;
      nc_q[0] <= {(max_d == '0), ctl0_q};
    end
  end

  for (genvar k = 0; k < SH_STEPS; k++) begin : g_shift
    localparam int unsigned AMT = 1 << (SH_STEPS - 1 - k);
    logic shift;
    assign shift = (nx_q[k][IN_W-1 -: AMT] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        nv_q[k+1] <= nv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          nm_q[k+1][i] <= shift ? (nm_q[k][i] << AMT) : nm_q[k][i];
        end
        nx_q[k+1] <= shift ? (nx_q[k] << AMT) : nx_q[k];
        nc_q[k+1] <= nc_q[k];
      end
    end
  end

  // Squares of the normalised window, then their sum.
  logic [NORM_W-1:0]   wq_q [3];
  logic [2*NORM_W-1:0] sq_q [3];
  logic [CW:0]         qc_q;
  logic                qv_q;

  logic [SUM_W-1:0]  sx_q [SQRT_STEPS+1];
  logic [SUM_W-1:0]  sr_q [SQRT_STEPS+1];
  logic [NORM_W-1:0] sw_q [SQRT_STEPS+1][3];
  logic [CW:0]       sc_q [SQRT_STEPS+1];
  logic              sv_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q    <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      qv_q    <= nv_q[SH_STEPS];
      sv_q[0] <= qv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        wq_q[i] <= nm_q[SH_STEPS][i][IN_W-1 -: NORM_W];
        sq_q[i] <= nm_q[SH_STEPS][i][IN_W-1 -: NORM_W] * nm_q[SH_STEPS][i][IN_W-1 -: NORM_W];
      end
      qc_q    <= nc_q[SH_STEPS];
      sx_q[0] <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      sr_q[0] <= '0;
      sw_q[0] <= wq_q;
      sc_q[0] <= qc_q;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SUM_W:0] trial;
    logic           take;
    assign trial = {1'b0, sr_q[j]} + {1'b0, BITV};
    assign take  = ({1'b0, sx_q[j]} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[j+1] <= take ? (sx_q[j] - trial[SUM_W-1:0]) : sx_q[j];
        sr_q[j+1] <= take ? ((sr_q[j] >> 1) + BITV) : (sr_q[j] >> 1);
        sw_q[j+1] <= sw_q[j];
        sc_q[j+1] <= sc_q[j];
      end
    end
  end

  // Dividends with the half-divisor rounding term.
  logic [ROOT_W-1:0] root;
  assign root = sr_q[SQRT_STEPS][ROOT_W-1:0];

  logic [ND-1:0]     rem_q  [QW+1][3];
  logic [QW-1:0]     quo_q  [QW+1][3];
  logic [ROOT_W-1:0] dl_q   [QW+1];
  logic [CW:0]       dc_q   [QW+1];
  logic              dv_q   [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= (ND'(sw_q[SQRT_STEPS][i]) << FRAC_BITS) + ND'(root >> 1);
        quo_q[0][i] <= '0;
      end
      dl_q[0] <= root;
      dc_q[0] <= sc_q[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int unsigned SH = QW - 1 - t;
    logic [DW-1:0] divisor;
    logic          take [3];
    assign divisor = DW'(dl_q[t]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = (DW'(rem_q[t][i]) >= divisor);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[t+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[t+1] <= dv_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[t+1][i] <= take[i] ? ND'(DW'(rem_q[t][i]) - divisor) : rem_q[t][i];
          quo_q[t+1][i] <= {quo_q[t][i][QW-2:0], take[i]};
        end
        dl_q[t+1] <= dl_q[t];
        dc_q[t+1] <= dc_q[t];
      end
    end
  end

  // Signs restored; a zero vector gives a zero result.
  logic [CW:0] fc;
  assign fc = dc_q[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (fc[CW]) begin
          res_o[i] <= '0;
        end else if (fc[2-i]) begin
          res_o[i] <= -$signed(RW'(quo_q[QW][i]));
        end else begin
          res_o[i] <= $signed(RW'(quo_q[QW][i]));
        end
      end
      zero_o <= fc[CW];
      side_o <= fc[CW-1:3];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/look_at_view_matrix_top.sv -----
// Top level of the right-handed look-at view matrix builder.
// Depends on lav_pkg and lav_unit.
`default_nettype none
// Usage
// The input channel carries one camera per transfer: eye position, view direction
// and up vector, each component signed fixed point with FRAC_BITS fractional bits.
// For each camera the output channel gives four transfers, the matrix rows 0 to 3
// in order, with last_row_o marking the fourth and degenerate_o flagging a zero
// direction, a zero up vector or a direction parallel to up on all four rows.
// The path from an input transfer to the first row runs through two normalisers,
// each with 32 square-root stages and FRAC_BITS + 1 division stages, plus ten
// stages of products, sums, rounding and the row register. Each camera takes
// four row transfers on the output channel; the pipeline itself takes a new camera
// in every cycle while the row register does not stall it.
// Reset clears every valid bit and the row register's busy flag, so no rows are pending.
// When the receiver stalls, the row register holds its row; once the last stage
// also holds a camera the whole pipeline freezes and in_ready_o falls, so nothing
// is lost or repeated. A new camera may be taken in the cycle the fourth row goes.
module look_at_view_matrix_top #(
  parameter int unsigned FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   dir_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   dir_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   dir_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          row_index_o,
  output logic signed [lav_pkg::DATA_W-1:0]   elem0_o,
  output logic signed [lav_pkg::DATA_W-1:0]   elem1_o,
  output logic signed [lav_pkg::DATA_W-1:0]   elem2_o,
  output logic signed [lav_pkg::DATA_W-1:0]   elem3_o,
  output logic                                degenerate_o,
  output logic                                last_row_o
);
  import lav_pkg::*;

  localparam int unsigned FW      = FRAC_BITS + 2;
  localparam int unsigned UW      = FRAC_BITS + 3;
  localparam int unsigned PW      = 3 * DATA_W;
  localparam int unsigned SIDE1_W = 2 * PW;
  localparam int unsigned SIDE2_W = PW + 3 * FW + 1;
  localparam int unsigned PROD_W  = 2 * DATA_W;

  typedef enum logic [1:0] {
    ROW_S = 2'd0,
    ROW_U = 2'd1,
    ROW_F = 2'd2,
    ROW_W = 2'd3
  } row_e;

  // Global advance: the pipeline moves unless its last stage holds a camera
  // that the row register cannot take.
  logic adv;
  logic load_ok;
  logic busy_q;
  row_e row_q;
  logic t8_v_q;

  assign load_ok    = !busy_q || (row_q == ROW_W && out_ready_i);
  assign adv        = !t8_v_q || load_ok;
  assign in_ready_o = adv;

  // Input register.
  logic               t0_v_q;
  logic signed [DATA_W-1:0] p0_q [3];
  logic signed [DATA_W-1:0] d0_q [3];
  logic signed [DATA_W-1:0] w0_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q <= 1'b0;
    end else if (adv) begin
      t0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= '{eye_x_i, eye_y_i, eye_z_i};
      d0_q <= '{dir_x_i, dir_y_i, dir_z_i};
      w0_q <= '{up_x_i, up_y_i, up_z_i};
    end
  end

  // Unit view direction f.
  logic                     u1_v;
  logic                     u1_z;
  logic signed [FW-1:0]     f1 [3];
  logic [SIDE1_W-1:0]       u1_side;
  logic signed [DATA_W-1:0] p1 [3];
  logic signed [DATA_W-1:0] w1 [3];

  lav_unit #(
    .IN_W     (DATA_W),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (SIDE1_W)
  ) u_norm_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(t0_v_q),
    .vec_i  (d0_q),
    .side_i ({p0_q[0], p0_q[1], p0_q[2], w0_q[0], w0_q[1], w0_q[2]}),
    .valid_o(u1_v),
    .zero_o (u1_z),
    .res_o  (f1),
    .side_o (u1_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i] = u1_side[SIDE1_W-1-DATA_W*i -: DATA_W];
      w1[i] = u1_side[PW-1-DATA_W*i -: DATA_W];
    end
  end

  // Cross product f x up, kept exact.
  logic                     t1_v_q, t2_v_q;
  logic signed [PROD_W-1:0] cp1_q [6];
  logic signed [PROD_W-1:0] c2_q [3];
  logic signed [DATA_W-1:0] p1_q [3], p2_q [3];
  logic signed [FW-1:0]     f1_q [3], f2_q [3];
  logic                     z1_q, z2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
    end else if (adv) begin
      t1_v_q <= u1_v;
      t2_v_q <= t1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp1_q[0] <= f1[1] * w1[2];
      cp1_q[1] <= f1[2] * w1[1];
      cp1_q[2] <= f1[2] * w1[0];
      cp1_q[3] <= f1[0] * w1[2];
      cp1_q[4] <= f1[0] * w1[1];
      cp1_q[5] <= f1[1] * w1[0];
      p1_q     <= p1;
      f1_q     <= f1;
      z1_q     <= u1_z;
      for (int i = 0; i < 3; i++) begin
        c2_q[i] <= cp1_q[2*i] - cp1_q[2*i+1];
      end
      p2_q <= p1_q;
      f2_q <= f1_q;
      z2_q <= z1_q;
    end
  end

  // Unit side vector s.
  logic                     u2_v;
  logic                     u2_z;
  logic signed [FW-1:0]     s3 [3];
  logic [SIDE2_W-1:0]       u2_side;
  logic signed [DATA_W-1:0] p3 [3];
  logic signed [FW-1:0]     f3 [3];

  lav_unit #(
    .IN_W     (PROD_W),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (SIDE2_W)
  ) u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(t2_v_q),
    .vec_i  (c2_q),
    .side_i ({p2_q[0], p2_q[1], p2_q[2], f2_q[0], f2_q[1], f2_q[2], z2_q}),
    .valid_o(u2_v),
    .zero_o (u2_z),
    .res_o  (s3),
    .side_o (u2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p3[i] = u2_side[SIDE2_W-1-DATA_W*i -: DATA_W];
      f3[i] = u2_side[3*FW-FW*i -: FW];
    end
  end

  // Products for u = s x f and the dot products with the eye position.
  logic                     t3_v_q, t4_v_q, t5_v_q, t6_v_q, t7_v_q;
  logic signed [PROD_W-1:0] sf3_q [6];
  logic signed [PROD_W-1:0] sp3_q [3], fp3_q [3];
  logic signed [FW-1:0]     s3_q [3], s4_q [3], s5_q [3], s6_q [3], s7_q [3];
  logic signed [FW-1:0]     f3_q [3], f4_q [3], f5_q [3], f6_q [3], f7_q [3];
  logic signed [DATA_W-1:0] p3_q [3], p4_q [3], p5_q [3];
  logic                     g3_q, g4_q, g5_q, g6_q, g7_q, g8_q;
  logic signed [WIDE_W-1:0] ux4_q [3];
  logic signed [WIDE_W-1:0] sd4_q, fd4_q;
  logic signed [UW-1:0]     u5_q [3], u6_q [3], u7_q [3];
  logic signed [WIDE_W-1:0] sr5_q, fr5_q, sr6_q, fr6_q, sr7_q, fr7_q;
  logic signed [WIDE_W-1:0] up6_q [3];
  logic signed [WIDE_W-1:0] ud7_q;
  logic signed [WIDE_W-1:0] ur7;
  logic [DATA_W-1:0]        r8_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      t5_v_q <= 1'b0;
      t6_v_q <= 1'b0;
      t7_v_q <= 1'b0;
      t8_v_q <= 1'b0;
    end else if (adv) begin
      t3_v_q <= u2_v;
      t4_v_q <= t3_v_q;
      t5_v_q <= t4_v_q;
      t6_v_q <= t5_v_q;
      t7_v_q <= t6_v_q;
      t8_v_q <= t7_v_q;
    end
  end

  assign ur7 = round_shr(ud7_q, FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 3: products.
      sf3_q[0] <= s3[1] * f3[2];
      sf3_q[1] <= s3[2] * f3[1];
      sf3_q[2] <= s3[2] * f3[0];
      sf3_q[3] <= s3[0] * f3[2];
      sf3_q[4] <= s3[0] * f3[1];
      sf3_q[5] <= s3[1] * f3[0];
      for (int i = 0; i < 3; i++) begin
        sp3_q[i] <= s3[i] * p3[i];
        fp3_q[i] <= f3[i] * p3[i];
      end
      s3_q <= s3;
      f3_q <= f3;
      p3_q <= p3;
      g3_q <= u2_z | u2_side[0];

      // Stage 4: exact differences and sums.
      for (int i = 0; i < 3; i++) begin
        ux4_q[i] <= WIDE_W'(sf3_q[2*i]) - WIDE_W'(sf3_q[2*i+1]);
      end
      sd4_q <= WIDE_W'(sp3_q[0]) + WIDE_W'(sp3_q[1]) + WIDE_W'(sp3_q[2]);
      fd4_q <= WIDE_W'(fp3_q[0]) + WIDE_W'(fp3_q[1]) + WIDE_W'(fp3_q[2]);
      s4_q  <= s3_q;
      f4_q  <= f3_q;
      p4_q  <= p3_q;
      g4_q  <= g3_q;

      // Stage 5: rounding back to the fixed-point scale.
      for (int i = 0; i < 3; i++) begin
        u5_q[i] <= UW'(round_shr(ux4_q[i], FRAC_BITS));
      end
      sr5_q <= round_shr(sd4_q, FRAC_BITS);
      fr5_q <= round_shr(fd4_q, FRAC_BITS);
      s5_q  <= s4_q;
      f5_q  <= f4_q;
      p5_q  <= p4_q;
      g5_q  <= g4_q;

      // Stage 6: u times the eye position.
      for (int i = 0; i < 3; i++) begin
        up6_q[i] <= WIDE_W'(u5_q[i]) * WIDE_W'(p5_q[i]);
      end
      u6_q  <= u5_q;
      s6_q  <= s5_q;
      f6_q  <= f5_q;
      sr6_q <= sr5_q;
      fr6_q <= fr5_q;
      g6_q  <= g5_q;

      // Stage 7: sum of the u dot product.
      ud7_q <= up6_q[0] + up6_q[1] + up6_q[2];
      u7_q  <= u6_q;
      s7_q  <= s6_q;
      f7_q  <= f6_q;
      sr7_q <= sr6_q;
      fr7_q <= fr6_q;
      g7_q  <= g6_q;

      // Stage 8: the three computed rows, saturated.
      for (int i = 0; i < 3; i++) begin
        r8_q[0][i] <= sat32(WIDE_W'(s7_q[i]));
        r8_q[1][i] <= sat32(WIDE_W'(u7_q[i]));
        r8_q[2][i] <= sat32(-WIDE_W'(f7_q[i]));
      end
      r8_q[0][3] <= sat32(-sr7_q);
      r8_q[1][3] <= sat32(-ur7);
      r8_q[2][3] <= sat32(fr7_q);
      g8_q       <= g7_q;
    end
  end

  // Row register: holds one matrix and sends its rows one transfer at a time.
  logic [DATA_W-1:0] rows_q [3][4];
  logic              degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= ROW_S;
    end else if (adv && t8_v_q) begin
      busy_q <= 1'b1;
      row_q  <= ROW_S;
    end else if (busy_q && out_ready_i) begin
      case (row_q)
        ROW_S:   row_q <= ROW_U;
        ROW_U:   row_q <= ROW_F;
        ROW_F:   row_q <= ROW_W;
        default: busy_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && t8_v_q) begin
      rows_q  <= r8_q;
      degen_q <= g8_q;
    end
  end

  assign out_valid_o  = busy_q;
  assign row_index_o  = row_q;
  assign degenerate_o = degen_q;
  assign last_row_o   = (row_q == ROW_W);

  always_comb begin
    case (row_q)
      ROW_S: begin
        elem0_o = rows_q[0][0];
        elem1_o = rows_q[0][1];
        elem2_o = rows_q[0][2];
        elem3_o = rows_q[0][3];
      end
      ROW_U: begin
        elem0_o = rows_q[1][0];
        elem1_o = rows_q[1][1];
        elem2_o = rows_q[1][2];
        elem3_o = rows_q[1][3];
      end
      ROW_F: begin
        elem0_o = rows_q[2][0];
        elem1_o = rows_q[2][1];
        elem2_o = rows_q[2][2];
        elem3_o = rows_q[2][3];
      end
      default: begin
        elem0_o = '0;
        elem1_o = '0;
        elem2_o = '0;
        elem3_o = DATA_W'(1) << FRAC_BITS;
      end
    endcase
  end

  // The input side only stalls while a matrix waits on the receiver.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !(last_row_o && out_ready_i))
    else $error("input stalled without a blocked output row");

  // The closing row is the constant row.
  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_index_o == ROW_W |->
      elem0_o == '0 && elem1_o == '0 && elem2_o == '0 &&
      elem3_o == (DATA_W'(1) << FRAC_BITS))
    else $error("constant row corrupted");

  // Rows of one matrix follow without a gap and share the degenerate flag.
  a_row_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && row_index_o == 2'($past(row_index_o) + 2'd1) && $stable(degenerate_o))
    else $error("row sequence broken");

  // A degenerate camera has an all-zero side row.
  a_degen_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o && row_index_o == ROW_S |->
      elem0_o == '0 && elem1_o == '0 && elem2_o == '0 && elem3_o == '0)
    else $error("degenerate side row not zero");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the look-at view matrix builder.
// Depends on lav_pkg and look_at_view_matrix_top; predicts all four rows per camera.
module tb_top;
  import lav_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned N_RANDOM = 150;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] up [3];
  } camera_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] e [4];
    logic               degen;
    logic               last;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] eye_x, eye_y, eye_z, dir_x, dir_y, dir_z, up_x, up_y, up_z;
  logic [1:0] row_index;
  logic signed [31:0] elem0, elem1, elem2, elem3;
  logic degenerate, last_row;

  camera_t camera_q[$];
  row_t    expected_rows[$];
  int      fail_count = 0;
  bit      stimulus_done = 0;

  look_at_view_matrix_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .eye_x_i(eye_x), .eye_y_i(eye_y), .eye_z_i(eye_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .up_x_i(up_x), .up_y_i(up_y), .up_z_i(up_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .row_index_o(row_index),
    .elem0_o(elem0), .elem1_o(elem1), .elem2_o(elem2), .elem3_o(elem3),
    .degenerate_o(degenerate), .last_row_o(last_row)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit, over an unsigned 64-bit value.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Normalises a vector to unit length in fixed point; returns 1 when it is zero.
  // The largest magnitude is brought into [2^30, 2^31), the others scaled with it, before the length is taken.
  function automatic bit normalise(input logic signed [65:0] v [3],
                                   output logic signed [65:0] unit [3]);
    logic [65:0] mag [3];
    logic [65:0] m, q;
    logic [63:0] sum, len;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) unit[i] = 0;
      return 1;
    end
    while (m >= (66'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (66'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + 64'(mag[i] * mag[i]);
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + 66'(len >> 1)) / 66'(len);
      unit[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 0;
  endfunction

  // Shift right by the fraction width, rounding half away from zero.
  function automatic logic signed [65:0] round_frac(input logic signed [65:0] x);
    logic signed [65:0] half;
    half = 66'sd1 <<< (FB - 1);
    if (x >= 0) return (x + half) >>> FB;
    return -((-x + half) >>> FB);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Works out the four view matrix rows of one camera and queues them.
  task automatic predict_view_rows(input camera_t c);
    logic signed [65:0] p [3], d [3], w [3], f [3], x [3], s [3], u [3];
    logic signed [65:0] m [4][4];
    bit degen;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      p[i] = c.eye[i];
      d[i] = c.dir[i];
      w[i] = c.up[i];
    end
    degen = normalise(d, f);
    x[0] = f[1] * w[2] - f[2] * w[1];
    x[1] = f[2] * w[0] - f[0] * w[2];
    x[2] = f[0] * w[1] - f[1] * w[0];
    if (normalise(x, s)) degen = 1;
    u[0] = round_frac(s[1] * f[2] - s[2] * f[1]);
    u[1] = round_frac(s[2] * f[0] - s[0] * f[2]);
    u[2] = round_frac(s[0] * f[1] - s[1] * f[0]);
    for (int i = 0; i < 3; i++) begin
      m[0][i] = s[i];
      m[1][i] = u[i];
      m[2][i] = -f[i];
      m[3][i] = 0;
    end
    m[0][3] = -round_frac(s[0] * p[0] + s[1] * p[1] + s[2] * p[2]);
    m[1][3] = -round_frac(u[0] * p[0] + u[1] * p[1] + u[2] * p[2]);
    m[2][3] = round_frac(f[0] * p[0] + f[1] * p[1] + f[2] * p[2]);
    m[3][3] = 66'sd1 <<< FB;
    for (int k = 0; k < 4; k++) begin
      r.row = 2'(k);
      for (int i = 0; i < 4; i++) r.e[i] = clamp32(m[k][i]);
      r.degen = degen;
      r.last = (k == 3);
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  function automatic logic signed [31:0] rand_wide();
    return $signed($urandom());
  endfunction

  // Values of modest size keep the translations mostly in range.
  function automatic logic signed [31:0] rand_mod();
    return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
  endfunction

  function automatic camera_t make_camera(input int ex, ey, ez, dx, dy, dz,
                                          input int ux, uy, uz);
    camera_t c;
    c.eye = '{ex, ey, ez};
    c.dir = '{dx, dy, dz};
    c.up = '{ux, uy, uz};
    return c;
  endfunction

  // Stimulus: a directed set of corner cameras, then random ones.
  initial begin
    camera_t c;
    int one;
    one = 1 << FB;
    // A plain camera looking down -z with +y up.
    camera_q.push_back(make_camera(0, 0, 5 * one, 0, 0, -one, 0, one, 0));
    camera_q.push_back(make_camera(one, 2 * one, 3 * one, one, one, one, 0, one, 0));
    // Zero direction.
    camera_q.push_back(make_camera(one, one, one, 0, 0, 0, 0, one, 0));
    // Direction parallel to up, and zero up.
    camera_q.push_back(make_camera(one, -one, one, 0, 3 * one, 0, 0, one, 0));
    camera_q.push_back(make_camera(one, -one, one, 0, -one, 0, 0, 7, 0));
    camera_q.push_back(make_camera(one, 2, 3, one, 0, 0, 0, 0, 0));
    // Extreme and tiny components, translations that saturate.
    camera_q.push_back(make_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 0, -1));
    camera_q.push_back(make_camera(32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h7fffffff, 32'h80000000));
    camera_q.push_back(make_camera(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    camera_q.push_back(make_camera(1, 1, 1, 1, 0, 0, 0, 1, 0));
    camera_q.push_back(make_camera(32'h7fffffff, 32'h80000000, 0, 1, -1, 0, 0, 0, 1));
    camera_q.push_back(make_camera(0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000, 0));
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_wide();
            c.dir[i] = rand_wide();
            c.up[i] = rand_wide();
          end
        end
        2: begin
          // Up along the direction, scaled: a parallel or zero-up case.
          for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_mod();
            c.dir[i] = rand_mod() >>> 4;
            c.up[i] = c.dir[i] * $signed($urandom_range(0, 6) - 3);
          end
        end
        3: begin
          for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_mod();
            c.dir[i] = ($urandom_range(0, 3) == 0) ? 0 : $signed($urandom_range(0, 8)) - 4;
            c.up[i] = rand_mod();
          end
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_mod();
            c.dir[i] = rand_mod();
            c.up[i] = rand_mod();
          end
        end
      endcase
      camera_q.push_back(c);
    end
  end

  // Driver: presents one camera at a time, with random idle gaps between them.
  int unsigned send_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 3);
      {eye_x, eye_y, eye_z, dir_x, dir_y, dir_z, up_x, up_y, up_z} <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_view_rows(make_camera(eye_x, eye_y, eye_z, dir_x, dir_y, dir_z,
                                      up_x, up_y, up_z));
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && camera_q.size() > 0) begin
          camera_t c;
          c = camera_q.pop_front();
          in_valid <= 1'b1;
          {eye_x, eye_y, eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
          {dir_x, dir_y, dir_z} <= {c.dir[0], c.dir[1], c.dir[2]};
          {up_x, up_y, up_z} <= {c.up[0], c.up[1], c.up[2]};
          // About seven cameras in sixteen go back to back.
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
          if (camera_q.size() == 0) stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares each row transfer with the oldest expected row, and
  // randomly stalls the receiver after each row.
  int unsigned stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("row with nothing expected", 32'(row_index), 0);
        end else begin
          row_t r;
          r = expected_rows.pop_front();
          if (row_index !== r.row) report_mismatch("row_index", 32'(row_index), 32'(r.row));
          if (elem0 !== r.e[0]) report_mismatch("elem0", elem0, r.e[0]);
          if (elem1 !== r.e[1]) report_mismatch("elem1", elem1, r.e[1]);
          if (elem2 !== r.e[2]) report_mismatch("elem2", elem2, r.e[2]);
          if (elem3 !== r.e[3]) report_mismatch("elem3", elem3, r.e[3]);
          if (degenerate !== r.degen)
            report_mismatch("degenerate", 32'(degenerate), 32'(r.degen));
          if (last_row !== r.last) report_mismatch("last_row", 32'(last_row), 32'(r.last));
        end
        if ($urandom_range(0, 3) == 0) begin
          out_ready <= 1'b1;
          stall_left <= 0;
        end else begin
          out_ready <= 1'b0;
          stall_left <= $urandom_range(0, 2);
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  int unsigned quiet_cycles;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Reset once, then wait for the stimulus to drain and the block to go quiet.
  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stimulus_done && !in_valid && expected_rows.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_rows.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
